[rtl/core/stq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;
  localparam int MAX_TIMERS = 64;
  localparam int TIME_BITS  = 32;
  localparam int ID_W   = $clog2(MAX_TIMERS);
  localparam int CNT_W  = $clog2(MAX_TIMERS + 1);
  localparam int OUT_LIMIT = 64;
  localparam int K_W    = $clog2(OUT_LIMIT + 1);

  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_ADJUST = 3'd1;
  localparam logic [2:0] ACT_DELETE = 3'd2;
  localparam logic [2:0] ACT_TICK   = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_PRESENT = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  timer_id;
    logic [31:0] expire_time;
    logic [31:0] now_time;
  } cmd_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [5:0] result_id;
    logic [1:0] status;
    logic       last_of_run;
  } res_t;
endpackage

[rtl/core/stq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface stq_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/stq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[rtl/core/sorted_timer_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_top
// Timer list kept in expiry order, with add, adjust, delete, clear and tick.
// ----------------------------------------------------------------------------
// channel  dir  payload
// cmd      in   action, timer_id, expire_time, now_time
// res      out  result_kind, result_id, status, last_of_run
//
// one item at a time; entries live in three rams (expiry, next, prev) with
// registered read. an add walks the list from the head to find its place and
// an adjust unlinks the entry before adding it again; a tick takes expired
// entries off the head one at a time. rst is synchronous and empties the
// list. a stalled result holds the tick between entries.
// ----------------------------------------------------------------------------
module sorted_timer_queue_top
  import stq_pkg::*;
(
  input logic clk,
  input logic rst,
  stq_if.sink   cmd,
  stq_if.source res
);
  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DECODE = 12'b000000000010,
    S_ULRD   = 12'b000000000100,
    S_ULWAIT = 12'b000000001000,
    S_ULFIX  = 12'b000000010000,
    S_ULFIX2 = 12'b000000100000,
    S_INWRE  = 12'b000001000000,
    S_WALK   = 12'b000010000000,
    S_CMP    = 12'b000100000000,
    S_LINK   = 12'b001000000000,
    S_LINK2  = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  state_t state;
  cmd_t   c;
  logic [MAX_TIMERS-1:0] in_use;
  logic [ID_W-1:0]  head, tail, cur, p_id, n_id, ul_id;
  logic [CNT_W-1:0] count, steps;
  logic [K_W-1:0]   k;
  logic             ticking, adj, found;
  res_t             w;
  res_t             r;
  logic             r_valid;
  logic             r_free, r_load, tick_end;

  logic            e_we, n_we, p_we;
  logic [ID_W-1:0] e_a, n_a, p_a;
  logic [TIME_BITS-1:0] e_wd, e_rd;
  logic [ID_W-1:0] n_wd, n_rd, p_wd, p_rd;

  stq_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TIMERS)) u_exp (
    .clk(clk), .we(e_we), .addr(e_a), .wdata(e_wd), .rdata(e_rd));
  stq_ram #(.WIDTH(ID_W), .DEPTH(MAX_TIMERS)) u_next (
    .clk(clk), .we(n_we), .addr(n_a), .wdata(n_wd), .rdata(n_rd));
  stq_ram #(.WIDTH(ID_W), .DEPTH(MAX_TIMERS)) u_prev (
    .clk(clk), .we(p_we), .addr(p_a), .wdata(p_wd), .rdata(p_rd));

  logic [ID_W-1:0] id;
  logic            id_ok;
  logic [TIME_BITS-1:0] new_exp;
  assign id      = c.timer_id[ID_W-1:0];
  assign id_ok   = {26'd0, c.timer_id} < 32'(MAX_TIMERS);
  assign new_exp = c.expire_time[TIME_BITS-1:0];

  assign cmd.ready = (state == S_IDLE);
  assign res.valid = r_valid;
  assign res.data  = r;

  // tick stops on an empty list, the item limit or a head not yet due
  assign tick_end = (count == '0) || (k == K_W'(OUT_LIMIT)) ||
                    (e_rd > c.now_time[TIME_BITS-1:0]);
  assign r_free   = !r_valid || res.ready;
  assign r_load   = r_free && ((state == S_OUT) ||
                    (state == S_ULWAIT && ticking && !tick_end && k != '0));

  // ram write strobes and addresses per state; second link writes in LINK2
  always_comb begin
    e_we = 1'b0; n_we = 1'b0; p_we = 1'b0;
    e_a = cur; n_a = cur; p_a = cur;
    e_wd = new_exp; n_wd = '0; p_wd = '0;
    unique case (state)
      S_DECODE: begin
        e_a = head; n_a = ul_id; p_a = ul_id;
        if (c.action == ACT_TICK) begin
          n_a = head; p_a = head;
        end
      end
      S_ULWAIT: begin
        e_a = head; n_a = ul_id; p_a = ul_id;
      end
      S_ULFIX: begin
        n_a = p_id; p_a = n_id;
        if (count <= CNT_W'(1)) begin
        end else if (ul_id == head) begin
        end else if (ul_id == tail) begin
          n_we = 1'b1; n_wd = p_id;
        end else begin
          n_we = 1'b1; n_wd = n_id; p_we = 1'b1; p_wd = p_id;
        end
      end
      S_ULFIX2: begin
        e_a = head; n_a = head; p_a = head;
      end
      S_INWRE: begin
        e_a = head; n_a = head; p_a = head;
      end
      S_WALK: begin
        e_a = cur; n_a = cur; p_a = cur;
      end
      S_LINK: begin
        e_we = 1'b1; e_a = id;
        if (count == '0) begin
          n_we = 1'b1; n_a = id; n_wd = id; p_we = 1'b1; p_a = id; p_wd = id;
        end else if (!found) begin
          n_we = 1'b1; n_a = tail; n_wd = id; p_we = 1'b1; p_a = id; p_wd = tail;
        end else if (cur == head) begin
          n_we = 1'b1; n_a = id; n_wd = cur; p_we = 1'b1; p_a = cur; p_wd = id;
        end else begin
          n_we = 1'b1; n_a = p_rd; n_wd = id; p_we = 1'b1; p_a = cur; p_wd = id;
        end
      end
      S_LINK2: begin
        // head already points at the new entry when it went in front
        if (count == '0) begin
        end else if (!found) begin
          n_we = 1'b1; n_a = id; n_wd = id;
        end else if (head == id) begin
          p_we = 1'b1; p_a = id; p_wd = id;
        end else begin
          n_we = 1'b1; n_a = id; n_wd = cur; p_we = 1'b1; p_a = id; p_wd = p_id;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (r_load) begin
      r <= w; r_valid <= 1'b1;
    end else if (res.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; in_use <= '0; head <= '0; tail <= '0; count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (cmd.valid) begin
          c <= cmd.data; state <= S_DECODE; k <= '0;
          ul_id <= cmd.data.timer_id[ID_W-1:0];
        end
        S_DECODE: begin
          ticking <= (c.action == ACT_TICK); adj <= (c.action == ACT_ADJUST);
          w.result_kind <= KIND_ACK; w.result_id <= c.timer_id;
          w.last_of_run <= 1'b1;
          priority case (1'b1)
            c.action == ACT_ADD: begin
              if (!id_ok || count >= CNT_W'(MAX_TIMERS)) begin
                w.status <= ST_FULL; state <= S_OUT;
              end else if (in_use[id]) begin
                w.status <= ST_PRESENT; state <= S_OUT;
              end else begin
                w.status <= ST_OK; state <= S_INWRE;
              end
            end
            c.action == ACT_ADJUST || c.action == ACT_DELETE: begin
              if (!id_ok || !in_use[id]) begin
                w.status <= ST_ABSENT; state <= S_OUT;
              end else begin
                w.status <= ST_OK; state <= S_ULWAIT;
              end
            end
            c.action == ACT_TICK: begin
              w.status <= ST_OK; ul_id <= head; state <= S_ULWAIT;
            end
            c.action == ACT_CLEAR: begin
              w.status <= ST_OK;
              in_use <= '0; head <= '0; tail <= '0; count <= '0; state <= S_OUT;
            end
            default: begin
              w.status <= ST_OK; state <= S_OUT;
            end
          endcase
        end
        S_ULWAIT: begin
          // e_rd holds head expiry for tick, n/p links of the entry
          p_id <= p_rd; n_id <= n_rd;
          if (ticking) begin
            if (tick_end) begin
              if (k == '0) begin
                w.result_kind <= KIND_NONE; w.result_id <= '0;
                w.status <= ST_OK; w.last_of_run <= 1'b1;
              end else w.last_of_run <= 1'b1;
              state <= S_OUT;
            end else if (k == '0 || r_free) begin
              // previous expired entry goes out as not last
              state <= S_ULFIX;
            end
          end else state <= S_ULFIX;
        end
        S_ULFIX: begin
          if (count <= CNT_W'(1)) begin
            head <= '0; tail <= '0;
          end else if (ul_id == head) head <= n_id;
          else if (ul_id == tail) tail <= p_id;
          in_use[ul_id] <= 1'b0;
          if (count > '0) count <= count - CNT_W'(1);
          if (ticking) begin
            w.result_kind <= KIND_EXPIRED; w.result_id <= 6'(ul_id);
            w.status <= ST_OK; w.last_of_run <= 1'b0;
            k <= k + K_W'(1);
            state <= S_ULFIX2;
          end else if (adj) state <= S_ULFIX2;
          else state <= S_OUT;
        end
        S_ULFIX2: begin
          if (ticking) begin
            ul_id <= head; state <= S_ULWAIT;
          end else state <= S_INWRE;
        end
        S_INWRE: begin
          cur <= head; steps <= '0; found <= 1'b0;
          state <= (count == '0) ? S_LINK : S_CMP;
        end
        S_WALK: state <= S_CMP;
        S_CMP: begin
          // e_rd and n_rd, p_rd belong to cur
          p_id <= p_rd;
          if (new_exp < e_rd) begin
            found <= 1'b1; state <= S_LINK;
          end else if (steps + CNT_W'(1) < count) begin
            steps <= steps + CNT_W'(1); cur <= n_rd; state <= S_WALK;
          end else state <= S_LINK;
        end
        S_LINK: begin
          state <= S_LINK2;
          if (count == '0) begin
            head <= id; tail <= id;
          end else if (!found) tail <= id;
          else if (cur == head) head <= id;
        end
        S_LINK2: begin
          in_use[id] <= 1'b1; count <= count + CNT_W'(1); state <= S_OUT;
        end
        S_OUT: begin
          if (r_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives commands into the sorted timer queue with random idling on both
// sides and checks every result against an in-bench linked-order model.
// ----------------------------------------------------------------------------
module testbench
  import stq_pkg::*;
();

  class timer_board;
    logic [31:0] expiry [MAX_TIMERS];
    bit          busy   [MAX_TIMERS];
    int          order  [$];            // ids in expiry order
    res_t        pending [$];
    int          errors;
    int          shown;

    function new();
      errors = 0;
      shown  = 0;
      foreach (busy[i]) busy[i] = 0;
    endfunction

    function void emit(logic [1:0] kind, logic [5:0] id, logic [1:0] st, bit last);
      res_t r;
      r.result_kind = kind;
      r.result_id   = id;
      r.status      = st;
      r.last_of_run = last;
      pending.push_back(r);
    endfunction

    function void place(int id);
      int pos;
      pos = order.size();
      for (int i = 0; i < order.size(); i++) begin
        if (expiry[id] < expiry[order[i]]) begin
          pos = i;
          break;
        end
      end
      order.insert(pos, id);
      busy[id] = 1;
    endfunction

    function void drop(int id);
      foreach (order[i]) begin
        if (order[i] == id) begin
          order.delete(i);
          break;
        end
      end
      busy[id] = 0;
    endfunction

    // note an accepted command and queue what it should produce
    function void note_cmd(cmd_t c);
      logic [1:0] st;
      int n;
      st = ST_OK;
      case (c.action)
        ACT_ADD: begin
          if (order.size() >= MAX_TIMERS) st = ST_FULL;
          else if (busy[c.timer_id]) st = ST_PRESENT;
          else begin
            expiry[c.timer_id] = c.expire_time;
            place(int'(c.timer_id));
          end
        end
        ACT_ADJUST: begin
          if (!busy[c.timer_id]) st = ST_ABSENT;
          else begin
            drop(int'(c.timer_id));
            expiry[c.timer_id] = c.expire_time;
            place(int'(c.timer_id));
          end
        end
        ACT_DELETE: begin
          if (!busy[c.timer_id]) st = ST_ABSENT;
          else drop(int'(c.timer_id));
        end
        ACT_TICK: begin
          n = 0;
          while (order.size() > 0 && n < OUT_LIMIT &&
                 expiry[order[0]] <= c.now_time) begin
            busy[order[0]] = 0;
            emit(KIND_EXPIRED, 6'(order[0]), ST_OK, 0);
            order.pop_front();
            n++;
          end
          if (n == 0) emit(KIND_NONE, 6'd0, ST_OK, 1);
          else pending[pending.size()-1].last_of_run = 1;
          return;
        end
        ACT_CLEAR: begin
          order.delete();
          foreach (busy[i]) busy[i] = 0;
        end
        default: ;
      endcase
      emit(KIND_ACK, c.timer_id, st, 1);
    endfunction

    function void check_res(res_t r);
      res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result %p", r);
        end
        return;
      end
      e = pending.pop_front();
      if (r !== e) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: expected %p, got %p", e, r);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  longint cycles;
  bit idle_ok;
  bit hold_res;
  int sent;
  timer_board board;

  stq_if #(.T(cmd_t)) cmd ();
  stq_if #(.T(res_t)) res ();

  sorted_timer_queue_top dut (.clk(clk), .rst(rst), .cmd(cmd), .res(res));

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 5000000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result side: random stall bursts, plus one long hold-off
  initial begin
    int gap;
    res.ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_res) begin
        res.ready <= 0;
      end else if (idle_ok && res.ready && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 19);
        res.ready <= 0;
        repeat (gap) @(posedge clk);
        res.ready <= 1;
      end else begin
        res.ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) board.check_res(res.data);
  end

  always @(posedge clk) begin
    if (!rst && cmd.valid && cmd.ready) board.note_cmd(cmd.data);
  end

  task automatic send_cmd(logic [2:0] act, logic [5:0] id, logic [31:0] exp_t,
                          logic [31:0] now_t);
    cmd_t c;
    int gap;
    c.action      = act;
    c.timer_id    = id;
    c.expire_time = exp_t;
    c.now_time    = now_t;
    if (idle_ok && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      cmd.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1;
    cmd.data  <= c;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [31:0] rand_time(int mode);
    case (mode)
      0: return $urandom_range(0, 40);
      1: return $urandom_range(0, 32'hFFFF_FFFE);
      default: return 32'hFFFF_FFF0 + $urandom_range(0, 14);
    endcase
  endfunction

  task automatic random_cmd(int id_span);
    int p;
    logic [2:0] act;
    logic [31:0] now_t;
    p = $urandom_range(0, 99);
    if (p < 40)      act = ACT_ADD;
    else if (p < 55) act = ACT_ADJUST;
    else if (p < 67) act = ACT_DELETE;
    else if (p < 95) act = ACT_TICK;
    else if (p < 97) act = ACT_CLEAR;
    else             act = 3'($urandom_range(5, 7));
    now_t = (p % 5 == 0) ? $urandom : $urandom_range(0, 45);
    send_cmd(act, 6'($urandom_range(0, id_span)), rand_time(p % 3 == 0 ? 1 : 0), now_t);
  endtask

  initial begin
    board = new();
    rst = 1;
    idle_ok = 0;
    hold_res = 0;
    sent = 0;
    cmd.valid = 0;
    cmd.data = '0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty-table cases, equal expiries, extremes, long tick
    send_cmd(ACT_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);
    send_cmd(ACT_DELETE, 6'd63, 32'd0, 32'd0);
    send_cmd(ACT_ADJUST, 6'd5, 32'd1, 32'd0);
    send_cmd(ACT_ADD, 6'd63, 32'hFFFF_FFFE, 32'd0);
    send_cmd(ACT_ADD, 6'd0, 32'd0, 32'd0);
    send_cmd(ACT_ADD, 6'd7, 32'd10, 32'd0);
    send_cmd(ACT_ADD, 6'd8, 32'd10, 32'd0);
    send_cmd(ACT_ADD, 6'd7, 32'd3, 32'd0);
    send_cmd(ACT_ADJUST, 6'd63, 32'd2, 32'd0);
    send_cmd(ACT_ADJUST, 6'd0, 32'd50, 32'd0);
    send_cmd(ACT_DELETE, 6'd8, 32'd0, 32'd0);
    send_cmd(3'd5, 6'd21, 32'h5555_5555, 32'hAAAA_AAAA);
    send_cmd(3'd7, 6'd42, 32'hAAAA_AAAA, 32'h5555_5555);
    send_cmd(ACT_TICK, 6'd0, 32'd0, 32'd1);
    send_cmd(ACT_TICK, 6'd0, 32'd0, 32'd10);
    send_cmd(ACT_CLEAR, 6'd33, 32'd0, 32'd0);
    for (int i = 0; i < 64; i++) send_cmd(ACT_ADD, 6'(i), 32'(i % 4), 32'd0);
    send_cmd(ACT_ADD, 6'd1, 32'd0, 32'd0);
    send_cmd(ACT_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);

    // random with idling; receiver held off for a long stretch early on
    idle_ok = 1;
    fork
      begin
        hold_res = 1;
        repeat (600) @(posedge clk);
        hold_res = 0;
      end
    join_none
    for (int i = 0; i < 180; i++) random_cmd(15);
    for (int i = 0; i < 120; i++) random_cmd(63);
    idle_ok = 0;
    for (int i = 0; i < 100; i++) random_cmd(31);
    send_cmd(ACT_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);
    cmd.valid <= 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/stq_pkg.sv
rtl/core/stq_if.sv
rtl/core/stq_ram.sv
rtl/core/sorted_timer_queue_top.sv
tb/testbench.sv
